>>> rtl/tls_certificate_list_parser_defines.svh
// ---------------------------------------------------------------------------
// TLS certificate list parser assertion macros
// Immediate-cycle and next-cycle implication checks on a rising clock.
// ---------------------------------------------------------------------------
`ifndef TLS_CERTIFICATE_LIST_PARSER_DEFINES_SVH
`define TLS_CERTIFICATE_LIST_PARSER_DEFINES_SVH

// same-cycle implication
`define TLSCL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TLSCL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tlscl_pkg.sv
// ---------------------------------------------------------------------------
// tlscl_pkg
// Types, codes and reset constants shared by the certificate list parser.
// ---------------------------------------------------------------------------
package tlscl_pkg;

   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ONLY  = 1'd1;

   localparam logic [7:0] MAX_ENTRIES_RESET = 8'd8;
   localparam logic       FIRST_ONLY_RESET  = 1'b0;

   typedef enum logic [7:0] {
      PH_CTX_LEN   = 8'b0000_0001,
      PH_CTX_BODY  = 8'b0000_0010,
      PH_LIST_LEN  = 8'b0000_0100,
      PH_CERT_LEN  = 8'b0000_1000,
      PH_CERT_BODY = 8'b0001_0000,
      PH_EXT_LEN   = 8'b0010_0000,
      PH_EXT_BODY  = 8'b0100_0000,
      PH_DONE      = 8'b1000_0000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CONTEXT = 2'd0,
      KIND_CERT    = 2'd1,
      KIND_FINAL   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TRUNCATED = 2'd1,
      ST_OVERRUN   = 2'd2,
      ST_TOO_MANY  = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [24:0] item_offset;
      logic [23:0] item_length;
      logic [7:0]  entry_index;
      status_type  status;
      logic [7:0]  entry_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [23:0] length_accum;
      logic [1:0]  length_bytes_left;
      logic [23:0] vector_left;
      logic [23:0] list_left;
      logic [24:0] position;
      logic [7:0]  entries_done;
      status_type  error_code;
      logic [24:0] cert_start;
      logic [23:0] cert_length;
   } state_type;

   typedef struct packed {
      logic    v0;
      logic    v1;
      rsp_type r0;
      rsp_type r1;
   } push_type;

   localparam state_type STATE_RESET = '{
      phase:             PH_CTX_LEN,
      length_accum:      24'd0,
      length_bytes_left: 2'd1,
      vector_left:       24'd0,
      list_left:         24'd0,
      position:          25'd0,
      entries_done:      8'd0,
      error_code:        ST_OK,
      cert_start:        25'd0,
      cert_length:       24'd0
   };

endpackage

>>> rtl/tlscl_step.sv
// ---------------------------------------------------------------------------
// tlscl_step
// Next-state and result logic for one message byte.
// ---------------------------------------------------------------------------
module tlscl_step
   import tlscl_pkg::*;
(
   input  state_type  cur,
   input  req_type    beat,
   input  logic [7:0] max_entries,
   input  logic       first_only,
   output state_type  nxt,
   output push_type   push
);

   logic [24:0] nxt_pos;
   logic [23:0] accum_new;
   logic [1:0]  left_new;
   logic        len_done;
   logic [23:0] vdec;
   logic        a_v;
   rsp_type     a_res;
   rsp_type     f_res;
   logic        do_start;
   logic        do_ext;
   logic        do_finish;

   assign nxt_pos   = (cur.position == '1) ? cur.position : cur.position + 25'd1;
   assign accum_new = {cur.length_accum[15:0], beat.data_byte};
   assign left_new  = cur.length_bytes_left - 2'd1;
   assign len_done  = (left_new == 2'd0);
   assign vdec      = cur.vector_left - 24'd1;

   always_comb begin
      nxt       = cur;
      a_v       = 1'b0;
      a_res     = '0;
      f_res     = '0;
      do_start  = 1'b0;
      do_ext    = 1'b0;
      do_finish = 1'b0;

      if (cur.phase inside {PH_CERT_LEN, PH_CERT_BODY, PH_EXT_LEN, PH_EXT_BODY} &&
          cur.list_left != 24'd0) begin
         nxt.list_left = cur.list_left - 24'd1;
      end

      case (cur.phase)
         PH_CTX_LEN: begin
            nxt.vector_left = {16'd0, beat.data_byte};
            if (beat.data_byte == 8'd0) begin
               a_v                   = 1'b1;
               a_res.kind            = KIND_CONTEXT;
               a_res.item_offset     = 25'd1;
               nxt.phase             = PH_LIST_LEN;
               nxt.length_bytes_left = 2'd3;
               nxt.length_accum      = 24'd0;
            end else begin
               nxt.phase = PH_CTX_BODY;
            end
         end
         PH_CTX_BODY: begin
            nxt.vector_left = vdec;
            if (vdec == 24'd0) begin
               a_v                   = 1'b1;
               a_res.kind            = KIND_CONTEXT;
               a_res.item_offset     = 25'd1;
               a_res.item_length     = 24'(nxt_pos - 25'd1);
               nxt.phase             = PH_LIST_LEN;
               nxt.length_bytes_left = 2'd3;
               nxt.length_accum      = 24'd0;
            end
         end
         PH_LIST_LEN: begin
            nxt.length_accum      = accum_new;
            nxt.length_bytes_left = left_new;
            if (len_done) begin
               nxt.list_left = accum_new;
               do_start      = 1'b1;
            end
         end
         PH_CERT_LEN: begin
            nxt.length_accum      = accum_new;
            nxt.length_bytes_left = left_new;
            if (len_done) begin
               nxt.cert_length = accum_new;
               if (accum_new > nxt.list_left) begin
                  nxt.error_code = ST_OVERRUN;
                  nxt.phase      = PH_DONE;
               end else begin
                  nxt.cert_start  = nxt_pos;
                  nxt.vector_left = accum_new;
                  if (accum_new == 24'd0) begin
                     do_ext = 1'b1;
                  end else begin
                     nxt.phase = PH_CERT_BODY;
                  end
               end
            end
         end
         PH_CERT_BODY: begin
            nxt.vector_left = vdec;
            if (vdec == 24'd0) begin
               do_ext = 1'b1;
            end
         end
         PH_EXT_LEN: begin
            nxt.length_accum      = accum_new;
            nxt.length_bytes_left = left_new;
            if (len_done) begin
               if (accum_new > nxt.list_left) begin
                  nxt.error_code = ST_OVERRUN;
                  nxt.phase      = PH_DONE;
               end else begin
                  nxt.vector_left = accum_new;
                  if (accum_new == 24'd0) begin
                     do_finish = 1'b1;
                  end else begin
                     nxt.phase = PH_EXT_BODY;
                  end
               end
            end
         end
         PH_EXT_BODY: begin
            nxt.vector_left = vdec;
            if (vdec == 24'd0) begin
               do_finish = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (do_ext) begin
         if (nxt.list_left < 24'd2) begin
            nxt.error_code = ST_OVERRUN;
            nxt.phase      = PH_DONE;
         end else begin
            nxt.phase             = PH_EXT_LEN;
            nxt.length_bytes_left = 2'd2;
            nxt.length_accum      = 24'd0;
         end
      end

      if (do_finish) begin
         a_v               = 1'b1;
         a_res.kind        = KIND_CERT;
         a_res.item_offset = nxt.cert_start;
         a_res.item_length = nxt.cert_length;
         a_res.entry_index = nxt.entries_done;
         nxt.entries_done  = nxt.entries_done + 8'd1;
         if (first_only) begin
            nxt.phase = PH_DONE;
         end else begin
            do_start = 1'b1;
         end
      end

      if (do_start) begin
         if (nxt.list_left == 24'd0) begin
            if (first_only && nxt.entries_done == 8'd0) begin
               nxt.error_code = ST_OVERRUN;
            end
            nxt.phase = PH_DONE;
         end else if (!first_only && nxt.entries_done >= max_entries) begin
            nxt.error_code = ST_TOO_MANY;
            nxt.phase      = PH_DONE;
         end else if (nxt.list_left < 24'd3) begin
            nxt.error_code = ST_OVERRUN;
            nxt.phase      = PH_DONE;
         end else begin
            nxt.phase             = PH_CERT_LEN;
            nxt.length_bytes_left = 2'd3;
            nxt.length_accum      = 24'd0;
         end
      end

      nxt.position = nxt_pos;

      if (beat.final_byte) begin
         f_res.kind        = KIND_FINAL;
         f_res.status      = (nxt.phase == PH_DONE) ? nxt.error_code : ST_TRUNCATED;
         f_res.entry_count = nxt.entries_done;
         f_res.last        = 1'b1;
         nxt               = STATE_RESET;
      end

      a_res.last = !beat.final_byte;

      push.v0 = a_v || beat.final_byte;
      push.v1 = a_v && beat.final_byte;
      push.r0 = a_v ? a_res : f_res;
      push.r1 = f_res;
   end

endmodule

>>> rtl/tlscl_queue.sv
// ---------------------------------------------------------------------------
// tlscl_queue
// Result queue: takes up to two result beats a cycle, drives one out.
// ---------------------------------------------------------------------------
module tlscl_queue
   import tlscl_pkg::*;
#(
   parameter int Depth = RSP_QUEUE_DEPTH
)
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     has_room,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_beat
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   rsp_type         slot_ff [Depth];
   logic [PtrW-1:0] head_ff, head_in;
   logic [PtrW-1:0] tail_ff, tail_in;
   logic [PtrW-1:0] tail1;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign tail1     = ptr_next(tail_ff);
   assign out_valid = (count_ff != '0);
   assign out_beat  = slot_ff[head_ff];
   assign pop       = out_valid && out_ready;
   assign has_room  = (count_ff <= CntW'(Depth - 2));

   always_comb begin
      head_in  = pop ? ptr_next(head_ff) : head_ff;
      tail_in  = push.v1 ? ptr_next(tail1) : (push.v0 ? tail1 : tail_ff);
      count_in = count_ff + CntW'(push.v0) + CntW'(push.v1) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         slot_ff[tail_ff] <= push.r0;
      end
      if (push.v1) begin
         slot_ff[tail1] <= push.r1;
      end
   end

endmodule

>>> rtl/tls_certificate_list_parser.sv
// Path: a byte accepted into the input register is stepped once the result
//   queue has room; its results are written into the queue and offered from there.
// Throughput: one byte per cycle while the result queue has room; a byte giving
//   two results queues both, and the queue drives them out one at a time.
// Reset: synchronous; parser state, config and queue return to reset values.
// ---------------------------------------------------------------------------
// tls_certificate_list_parser
// TLS 1.3 Certificate message walker: context span, entry spans and status.
// ---------------------------------------------------------------------------
module tls_certificate_list_parser
   import tlscl_pkg::*;
#(
   parameter int RspDepth = RSP_QUEUE_DEPTH
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_beat,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   req_type    in_beat_ff;
   state_type  state_ff, state_nxt;
   logic [7:0] max_entries_ff;
   logic       first_only_ff;
   push_type   step_push;
   push_type   push;
   logic       has_room;
   logic       process;
   logic       req_fire;

   assign process   = in_valid_ff && has_room;
   assign req_ready = !in_valid_ff || process;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
      push    = step_push;
      push.v0 = step_push.v0 && process;
      push.v1 = step_push.v1 && process;
   end

   tlscl_step u_step (
      .cur         (state_ff),
      .beat        (in_beat_ff),
      .max_entries (max_entries_ff),
      .first_only  (first_only_ff),
      .nxt         (state_nxt),
      .push        (step_push)
   );

   tlscl_queue #(
      .Depth (RspDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_beat  (rsp_beat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         state_ff       <= STATE_RESET;
         max_entries_ff <= MAX_ENTRIES_RESET;
         first_only_ff  <= FIRST_ONLY_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (process) begin
            state_ff <= state_nxt;
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_MAX_ENTRIES: max_entries_ff <= csr_wdata[7:0];
               CSR_FIRST_ONLY:  first_only_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_beat_ff <= req_beat;
      end
   end

endmodule

>>> rtl/tlscl_checker.sv
// ---------------------------------------------------------------------------
// tlscl_checker
// Port-level checks on the result channel, bound to the parser top level.
// ---------------------------------------------------------------------------
`include "tls_certificate_list_parser_defines.svh"

module tlscl_checker
   import tlscl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_beat
);

   `TLSCL_ASSERT_IMP(a_final_is_last, clock, reset, rsp_valid && rsp_beat.kind == KIND_FINAL,
                     rsp_beat.last, "final status beat without last")

   `TLSCL_ASSERT_IMP(a_span_fields, clock, reset, rsp_valid && rsp_beat.kind != KIND_FINAL,
                     rsp_beat.status == ST_OK && rsp_beat.entry_count == 8'd0,
                     "status or count set on a span beat")

   `TLSCL_ASSERT_IMP(a_context_offset, clock, reset, rsp_valid && rsp_beat.kind == KIND_CONTEXT,
                     rsp_beat.item_offset == 25'd1 && rsp_beat.entry_index == 8'd0,
                     "context span at wrong offset")

   `TLSCL_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid,
                     "result valid right after reset")

   `TLSCL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_beat), "stalled result beat changed")

endmodule

bind tls_certificate_list_parser tlscl_checker u_tlscl_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tls_certificate_list_parser testbench
// Streams Certificate messages byte by byte through the parser and checks
// every context span, certificate entry and final status against a
// cycle-free predictor, over several max_entries / first_only settings,
// with random stalls on both channels and one long result back-pressure.
// ---------------------------------------------------------------------------
module testbench;
   import tlscl_pkg::*;

   localparam int HoldCycles    = 300;
   localparam int WatchdogLimit = 4000;
   localparam int PhaseItems    = 240;
   localparam int PrintLimit    = 100;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   req_type               req_beat     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   rsp_type               rsp_beat;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   tls_certificate_list_parser DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_beat     (req_beat),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_beat     (rsp_beat),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser shadow state
   logic [7:0]  cfg_max_entries;
   logic        cfg_first_only;
   phase_type   pr_phase;
   logic [23:0] pr_accum;
   logic [1:0]  pr_len_left;
   logic [23:0] pr_vec_left;
   logic [23:0] pr_list_left;
   logic [24:0] pr_pos;
   logic [7:0]  pr_entries;
   status_type  pr_error;
   logic [24:0] pr_cert_start;
   logic [23:0] pr_cert_size;

   rsp_type    byte_reports[$];
   rsp_type    expected_reports[$];
   req_type    pending_bytes[$];
   logic [7:0] msg_bytes[$];

   int errors      = 0;
   int items_sent  = 0;
   int hold_left   = 0;
   int idle_cycles = 0;
   bit steady      = 1'b0;
   bit hold_trigger = 1'b0;

   task restart_message;
      pr_phase      = PH_CTX_LEN;
      pr_accum      = '0;
      pr_len_left   = 2'd1;
      pr_vec_left   = '0;
      pr_list_left  = '0;
      pr_pos        = '0;
      pr_entries    = '0;
      pr_error      = ST_OK;
      pr_cert_start = '0;
      pr_cert_size  = '0;
   endtask

   task report(input kind_type k, input logic [24:0] off, input logic [23:0] len,
               input logic [7:0] idx, input status_type st, input logic [7:0] cnt);
      rsp_type r;
      r.kind        = k;
      r.item_offset = off;
      r.item_length = len;
      r.entry_index = idx;
      r.status      = st;
      r.entry_count = cnt;
      r.last        = 1'b0;
      byte_reports.push_back(r);
   endtask

   task abort_message(input status_type code);
      pr_error = code;
      pr_phase = PH_DONE;
   endtask

   task expect_length(input phase_type ph, input logic [1:0] nbytes);
      pr_phase    = ph;
      pr_len_left = nbytes;
      pr_accum    = '0;
   endtask

   task open_entry;
      if (pr_list_left == 0) begin
         if (cfg_first_only && pr_entries == 0) abort_message(ST_OVERRUN);
         else pr_phase = PH_DONE;
      end else if (!cfg_first_only && pr_entries >= cfg_max_entries) begin
         abort_message(ST_TOO_MANY);
      end else if (pr_list_left < 24'd3) begin
         abort_message(ST_OVERRUN);
      end else begin
         expect_length(PH_CERT_LEN, 2'd3);
      end
   endtask

   task close_entry;
      report(KIND_CERT, pr_cert_start, pr_cert_size, pr_entries, ST_OK, 8'd0);
      pr_entries++;
      if (cfg_first_only) pr_phase = PH_DONE;
      else open_entry();
   endtask

   task open_extensions;
      if (pr_list_left < 24'd2) abort_message(ST_OVERRUN);
      else expect_length(PH_EXT_LEN, 2'd2);
   endtask

   function automatic logic take_length_byte(input logic [7:0] b);
      pr_accum    = {pr_accum[15:0], b};
      pr_len_left = pr_len_left - 2'd1;
      return pr_len_left == 2'd0;
   endfunction

   task parse_byte(input req_type beat);
      logic [24:0] next_pos;
      logic [24:0] ctx_end;
      byte_reports.delete();
      next_pos = (pr_pos != '1) ? pr_pos + 25'd1 : pr_pos;
      if ((pr_phase == PH_CERT_LEN || pr_phase == PH_CERT_BODY ||
           pr_phase == PH_EXT_LEN || pr_phase == PH_EXT_BODY) && pr_list_left != 0)
         pr_list_left--;
      case (pr_phase)
         PH_CTX_LEN: begin
            pr_vec_left = {16'd0, beat.data_byte};
            if (beat.data_byte == 8'd0) begin
               report(KIND_CONTEXT, 25'd1, 24'd0, 8'd0, ST_OK, 8'd0);
               expect_length(PH_LIST_LEN, 2'd3);
            end else begin
               pr_phase = PH_CTX_BODY;
            end
         end
         PH_CTX_BODY: begin
            pr_vec_left--;
            if (pr_vec_left == 0) begin
               ctx_end = next_pos - 25'd1;
               report(KIND_CONTEXT, 25'd1, ctx_end[23:0], 8'd0, ST_OK, 8'd0);
               expect_length(PH_LIST_LEN, 2'd3);
            end
         end
         PH_LIST_LEN: begin
            if (take_length_byte(beat.data_byte)) begin
               pr_list_left = pr_accum;
               open_entry();
            end
         end
         PH_CERT_LEN: begin
            if (take_length_byte(beat.data_byte)) begin
               pr_cert_size = pr_accum;
               if (pr_cert_size > pr_list_left) begin
                  abort_message(ST_OVERRUN);
               end else begin
                  pr_cert_start = next_pos;
                  pr_vec_left   = pr_cert_size;
                  if (pr_vec_left == 0) open_extensions();
                  else pr_phase = PH_CERT_BODY;
               end
            end
         end
         PH_CERT_BODY: begin
            pr_vec_left--;
            if (pr_vec_left == 0) open_extensions();
         end
         PH_EXT_LEN: begin
            if (take_length_byte(beat.data_byte)) begin
               if (pr_accum > pr_list_left) begin
                  abort_message(ST_OVERRUN);
               end else begin
                  pr_vec_left = pr_accum;
                  if (pr_vec_left == 0) close_entry();
                  else pr_phase = PH_EXT_BODY;
               end
            end
         end
         PH_EXT_BODY: begin
            pr_vec_left--;
            if (pr_vec_left == 0) close_entry();
         end
         default: ;
      endcase
      pr_pos = next_pos;
      if (beat.final_byte) begin
         report(KIND_FINAL, 25'd0, 24'd0, 8'd0,
                (pr_phase == PH_DONE) ? pr_error : ST_TRUNCATED, pr_entries);
         restart_message();
      end
      if (byte_reports.size() != 0) byte_reports[byte_reports.size() - 1].last = 1'b1;
      foreach (byte_reports[i]) expected_reports.push_back(byte_reports[i]);
   endtask

   // byte driver and predictor feed
   always @(posedge clock) begin
      if (reset) begin
         req_valid       <= 1'b0;
         cfg_max_entries = MAX_ENTRIES_RESET;
         cfg_first_only  = FIRST_ONLY_RESET;
         restart_message();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_MAX_ENTRIES) cfg_max_entries = csr_wdata[7:0];
            else if (csr_index == CSR_FIRST_ONLY) cfg_first_only = csr_wdata[0];
         end
         if (req_valid && req_ready) parse_byte(req_beat);
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
               req_valid <= 1'b1;
               req_beat  <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               errors++;
               if (errors <= PrintLimit)
                  $display("%0t: unexpected beat, expected none, got %p", $time, rsp_beat);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_beat.kind !== want.kind ||
                   rsp_beat.item_offset !== want.item_offset ||
                   rsp_beat.item_length !== want.item_length ||
                   rsp_beat.entry_index !== want.entry_index ||
                   rsp_beat.status !== want.status ||
                   rsp_beat.entry_count !== want.entry_count ||
                   rsp_beat.last !== want.last) begin
                  errors++;
                  if (errors <= PrintLimit)
                     $display("%0t: expected %p, got %p", $time, want, rsp_beat);
               end
            end
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (hold_trigger) begin
            rsp_ready <= 1'b0;
            hold_left <= HoldCycles;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 25);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("tls_certificate_list_parser: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task wait_drained;
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task write_register(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task put_length(input logic [23:0] value, input int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) msg_bytes.push_back(value[8*i +: 8]);
   endtask

   task put_noise(input int count);
      repeat (count) msg_bytes.push_back(8'($urandom_range(255)));
   endtask

   // keep == 0 sends the whole message, otherwise only its first keep bytes
   task send_message(input int keep);
      int n;
      n = (keep == 0 || keep > msg_bytes.size()) ? msg_bytes.size() : keep;
      for (int i = 0; i < n; i++)
         pending_bytes.push_back(req_type'{msg_bytes[i], i == n - 1});
      items_sent += n;
      msg_bytes.delete();
   endtask

   task build_chain(input int ctx_len, input int entries, input int list_skew,
                    input bit list_max, input int trailing);
      int          cert_size[$];
      int          ext_len[$];
      int          list_len;
      logic [23:0] declared;
      list_len = 0;
      for (int i = 0; i < entries; i++) begin
         cert_size.push_back(($urandom_range(99) < 5) ? $urandom_range(9, 40)
                                                      : $urandom_range(0, 5));
         ext_len.push_back($urandom_range(0, 2));
         list_len += 5 + cert_size[i] + ext_len[i];
      end
      declared = list_max ? 24'hFFFFFF : 24'(list_len + list_skew);
      msg_bytes.push_back(ctx_len[7:0]);
      put_noise(ctx_len);
      put_length(declared, 3);
      for (int i = 0; i < entries; i++) begin
         put_length(24'(cert_size[i]), 3);
         put_noise(cert_size[i]);
         put_length(24'(ext_len[i]), 2);
         put_noise(ext_len[i]);
      end
      put_noise(trailing);
   endtask

   task random_message;
      int pick;
      int skew;
      bit list_max;
      int keep;
      pick = $urandom_range(99);
      if (pick < 8) begin
         put_noise($urandom_range(1, 12));
         send_message(0);
      end else begin
         skew     = 0;
         list_max = 1'b0;
         pick     = $urandom_range(99);
         if (pick >= 95) list_max = 1'b1;
         else if (pick >= 80) skew = $urandom_range(12) - 6;
         build_chain(($urandom_range(99) == 0) ? 255 : $urandom_range(3),
                     ($urandom_range(99) < 10) ? $urandom_range(5, 10) : $urandom_range(3),
                     skew, list_max,
                     ($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0);
         if ($urandom_range(99) < 10)
            msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom_range(255));
         keep = ($urandom_range(99) < 12) ? $urandom_range(1, msg_bytes.size()) : 0;
         send_message(keep);
      end
   endtask

   logic [7:0] phase_max[7]   = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd255, 8'd2, 8'd8};
   logic       phase_first[7] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

   initial begin
      int target;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // final on the context length byte
      msg_bytes = {8'h00};
      send_message(0);
      // empty list, chain mode
      msg_bytes = {8'h00, 8'h00, 8'h00, 8'h00};
      send_message(0);
      // one empty entry with a trailing byte after the list
      msg_bytes = {8'h01, 8'hFF, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h5A};
      send_message(0);
      // maximal lengths: certificate overruns the list
      msg_bytes = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_message(0);

      for (int p = -1; p < 7; p++) begin
         wait_drained();
         if (p >= 0) begin
            write_register(CSR_MAX_ENTRIES, (p == 6) ? 8'($urandom_range(255)) : phase_max[p]);
            write_register(CSR_FIRST_ONLY, {7'd0, phase_first[p]});
         end
         steady = (p == 3);
         target = items_sent + PhaseItems / 2;
         while (items_sent < target) random_message();
         if (p == 1) begin
            @(posedge clock) hold_trigger <= 1'b1;
            @(posedge clock) hold_trigger <= 1'b0;
         end
         wait_drained();
         target = items_sent + PhaseItems / 2;
         while (items_sent < target) random_message();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("tls_certificate_list_parser: match");
      end else begin
         $display("tls_certificate_list_parser: mismatch");
      end
      $finish;
   end

endmodule
